[rtl/preemptive_priority_scheduler_top_defines.svh]
// ----------------------------------------------------------------------------
// Preemptive priority scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pps_pkg.sv]
// ----------------------------------------------------------------------------
// Scheduler package
// Types, widths and constants shared by the scheduler modules.
// ----------------------------------------------------------------------------
package pps_pkg;

	// Default number of task slots.
	localparam int MAX_TASKS_DEF = 64;

	// Field widths.
	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int TIME_W  = 24;
	localparam int SLOT_W  = 6;
	localparam int CNT_W   = 7;

	// The clock stops at its largest value.
	localparam logic [TIME_W-1:0] CLOCK_MAX = {TIME_W{1'b1}};

	// Input word modes.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// One row of the task table.
	typedef struct packed {
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [BURST_W-1:0] remaining;
		logic [PRIO_W-1:0]  prio;
		logic [TIME_W-1:0]  start;
	} task_row_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_CALC,
		ST_EMIT
	} pps_state_t;

endpackage

[rtl/preemptive_priority_scheduler_top.sv]
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Task table with a slot-by-slot priority scan per time tick.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                 | Contents
//  --------+---------------------------+--------------------------------------
//  cfg     | cfg_we                    | cfg_wdata: task_count
//  in      | in_valid / in_stall       | mode, slot, arrival, burst, prio
//  out     | out_valid / out_stall     | ran, run_slot, time_now, finished,
//          |                           | first_run, turnaround, waiting, all_done
//
//  A load word is written into the table on the edge that accepts it; the
//  next word can follow in the next cycle.
//  A tick word that runs a task scans min(task_count, MAX_TASKS) table rows,
//  one row per scan cycle through the single read port, drains the scan,
//  then reads, updates and emits. An idle tick skips the read and update.
//  The next word is taken once the result is in the output register.
//  Reset clears the sequencer, the clock and task_count; table rows are
//  undefined until loaded. A result waits in the output register while
//  out_stall is high; loads are still taken meanwhile.
//
module preemptive_priority_scheduler_top
	import pps_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [ARR_W-1:0]    arrival,
	input  logic [BURST_W-1:0]  burst,
	input  logic [PRIO_W-1:0]   prio,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                ran,
	output logic [SLOT_W-1:0]   run_slot,
	output logic [TIME_W-1:0]   time_now,
	output logic                finished,
	output logic [TIME_W-1:0]   first_run,
	output logic [TIME_W-1:0]   turnaround,
	output logic [TIME_W-1:0]   waiting,
	output logic                all_done
);

`include "preemptive_priority_scheduler_top_defines.svh"

	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = AW + 1;

	pps_state_t state_q, state_d;

	logic [CNT_W-1:0]  task_count_q;
	logic [CW-1:0]     lim;
	logic [TIME_W-1:0] clock_q;
	logic [TIME_W-1:0] clock_next;

	// Scan bookkeeping.
	logic [CW-1:0]     issue_q;
	logic              scan_vld_s1;
	logic [AW-1:0]     scan_idx_s1;
	logic              found_q;
	logic [AW-1:0]     best_idx_q;
	logic [PRIO_W-1:0] best_prio_q;
	logic [ARR_W-1:0]  best_arr_q;
	logic [1:0]        pend_q;

	// Update results.
	logic [TIME_W-1:0]  first_q;
	logic               fin_q;
	logic [TIME_W-1:0]  tat_q;
	logic [BURST_W-1:0] burst_q;

	// Output register.
	logic               out_valid_q;
	logic               ran_q;
	logic [SLOT_W-1:0]  run_slot_q;
	logic [TIME_W-1:0]  time_now_q;
	logic               finished_q;
	logic [TIME_W-1:0]  first_run_q;
	logic [TIME_W-1:0]  turnaround_q;
	logic [TIME_W-1:0]  waiting_q;
	logic               all_done_q;

	// Table ports.
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	task_row_t     mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	task_row_t     mem_rdata;

	logic in_acc;
	logic load_acc;
	logic tick_acc;
	logic out_free;
	logic eligible;
	logic better;
	logic [TIME_W-1:0]  calc_first;
	logic [BURST_W-1:0] calc_rem;
	logic [TIME_W-1:0]  calc_tat;
	logic [TIME_W-1:0]  emit_wait;

	// Handshake decode.
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign load_acc = in_acc && (mode == MODE_LOAD) && (32'(slot) < MAX_TASKS);
	assign tick_acc = in_acc && (mode == MODE_TICK);
	assign out_free = !out_valid_q || !out_stall;

	// Slots that take part, capped at the table size.
	assign lim = (32'(task_count_q) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(task_count_q);

	// Saturating clock increment.
	assign clock_next = (clock_q == CLOCK_MAX) ? clock_q : clock_q + 1'b1;

	// Shared scan comparator: ready rows, lowest priority, then earliest arrival.
	assign eligible = (mem_rdata.remaining != '0) &&
		({{(TIME_W-ARR_W){1'b0}}, mem_rdata.arrival} <= clock_q);
	assign better = !found_q || (mem_rdata.prio < best_prio_q) ||
		((mem_rdata.prio == best_prio_q) && (mem_rdata.arrival < best_arr_q));

	// Update of the chosen row.
	assign calc_first = (mem_rdata.remaining == mem_rdata.burst) ? clock_q : mem_rdata.start;
	assign calc_rem   = mem_rdata.remaining - 1'b1;
	assign calc_tat   = clock_next - {{(TIME_W-ARR_W){1'b0}}, mem_rdata.arrival};

	// Waiting time, floored at zero.
	assign emit_wait = (tat_q >= {{(TIME_W-BURST_W){1'b0}}, burst_q}) ?
		tat_q - {{(TIME_W-BURST_W){1'b0}}, burst_q} : '0;

	// Sequencer: next state and table port control.
	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_raddr = issue_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = AW'(slot);
		mem_wdata = '{arrival: arrival, burst: burst, remaining: burst, prio: prio,
			start: '0};
		unique case (state_q)
			ST_IDLE: begin
				mem_we = load_acc;
				if (tick_acc) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				mem_re = (issue_q < lim);
				if (issue_q == lim && !scan_vld_s1) begin
					state_d = found_q ? ST_READ : ST_EMIT;
				end
			end
			ST_READ: begin
				mem_re    = 1'b1;
				mem_raddr = best_idx_q;
				state_d   = ST_CALC;
			end
			ST_CALC: begin
				mem_we    = 1'b1;
				mem_waddr = best_idx_q;
				mem_wdata = mem_rdata;
				mem_wdata.remaining = calc_rem;
				mem_wdata.start     = calc_first;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
		end else if (cfg_we) begin
			task_count_q <= cfg_wdata;
		end
	end

	// Scan counters and the running best candidate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q     <= '0;
			scan_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
			pend_q      <= '0;
		end else begin
			scan_vld_s1 <= (state_q == ST_SCAN) && mem_re;
			if (tick_acc) begin
				issue_q <= '0;
				found_q <= 1'b0;
				pend_q  <= '0;
			end else begin
				if ((state_q == ST_SCAN) && mem_re) begin
					issue_q <= issue_q + 1'b1;
				end
				if (scan_vld_s1) begin
					if (mem_rdata.remaining != '0 && pend_q != 2'd2) begin
						pend_q <= pend_q + 1'b1;
					end
					if (eligible && better) begin
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	// Best candidate payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			scan_idx_s1 <= issue_q[AW-1:0];
		end
		if (scan_vld_s1 && eligible && better) begin
			best_idx_q  <= scan_idx_s1;
			best_prio_q <= mem_rdata.prio;
			best_arr_q  <= mem_rdata.arrival;
		end
	end

	// Figures of the chosen task.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b0;
		end else if (tick_acc) begin
			fin_q <= 1'b0;
		end else if (state_q == ST_CALC) begin
			fin_q <= (calc_rem == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			first_q <= calc_first;
			tat_q   <= calc_tat;
			burst_q <= mem_rdata.burst;
		end
	end

	// Clock and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				clock_q     <= clock_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			ran_q        <= found_q;
			run_slot_q   <= found_q ? SLOT_W'(best_idx_q) : '0;
			time_now_q   <= clock_next;
			finished_q   <= found_q && fin_q;
			first_run_q  <= found_q ? first_q : '0;
			turnaround_q <= (found_q && fin_q) ? tat_q : '0;
			waiting_q    <= (found_q && fin_q) ? emit_wait : '0;
			all_done_q   <= (pend_q == 2'd0) || (pend_q == 2'd1 && found_q && fin_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign ran        = ran_q;
	assign run_slot   = run_slot_q;
	assign time_now   = time_now_q;
	assign finished   = finished_q;
	assign first_run  = first_run_q;
	assign turnaround = turnaround_q;
	assign waiting    = waiting_q;
	assign all_done   = all_done_q;

	// Task table.
	pps_task_mem #(
		.DEPTH (MAX_TASKS)
	) u_task_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The scan never issues a read beyond the active slots.
	`PPS_ASSERT_NOW(a_scan_bound, clk, arst_n, state_q == ST_SCAN, issue_q <= lim, "scan overrun")
	// A chosen slot always lies inside the active range.
	`PPS_ASSERT_NOW(a_best_range, clk, arst_n, state_q == ST_READ, {1'b0, best_idx_q} < lim, "best slot out of range")
	// A completion is only reported for a task that ran.
	`PPS_ASSERT_NOW(a_fin_ran, clk, arst_n, out_valid && finished, ran, "finished without run")
	// Every tick moves the clock past zero.
	`PPS_ASSERT_NOW(a_time_pos, clk, arst_n, out_valid, time_now != '0, "clock did not advance")
	// A waiting result holds the emit step back.
	`PPS_ASSERT_NEXT(a_emit_hold, clk, arst_n, state_q == ST_EMIT && out_valid_q && out_stall, state_q == ST_EMIT, "emit overran result")

endmodule

[rtl/pps_task_mem.sv]
// ----------------------------------------------------------------------------
// Scheduler task table
// One write port and one registered read port over the task rows.
// ----------------------------------------------------------------------------
module pps_task_mem
	import pps_pkg::*;
#(
	parameter int DEPTH = MAX_TASKS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  task_row_t                wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output task_row_t                rdata
);

	task_row_t mem_q [DEPTH];
	task_row_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[bench/preemptive_priority_scheduler_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Drives load and tick words into the scheduler under random idling and
// output back-pressure. A local copy of the task table predicts every tick
// report. Each report is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top_test
	import pps_pkg::*;
();

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_WAIT  = 80;
	localparam int HOLD_STRETCH = 300;

	// One tick report as the block presents it.
	typedef struct {
		logic              ran;
		logic [SLOT_W-1:0] run_slot;
		logic [TIME_W-1:0] time_now;
		logic              finished;
		logic [TIME_W-1:0] first_run;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic              all_done;
	} tick_report_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_we     = 1'b0;
	logic [CNT_W-1:0]   cfg_wdata  = '0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic               mode       = MODE_LOAD;
	logic [SLOT_W-1:0]  slot       = '0;
	logic [ARR_W-1:0]   arrival    = '0;
	logic [BURST_W-1:0] burst      = '0;
	logic [PRIO_W-1:0]  prio       = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic               ran;
	logic [SLOT_W-1:0]  run_slot;
	logic [TIME_W-1:0]  time_now;
	logic               finished;
	logic [TIME_W-1:0]  first_run;
	logic [TIME_W-1:0]  turnaround;
	logic [TIME_W-1:0]  waiting;
	logic               all_done;

	// Predicted task table, clock and configuration.
	logic [ARR_W-1:0]   sched_arrival [MAX_TASKS_DEF];
	logic [BURST_W-1:0] sched_burst [MAX_TASKS_DEF];
	logic [BURST_W-1:0] sched_left [MAX_TASKS_DEF];
	logic [PRIO_W-1:0]  sched_prio [MAX_TASKS_DEF];
	logic [TIME_W-1:0]  sched_start [MAX_TASKS_DEF];
	bit                 sched_done [MAX_TASKS_DEF];
	logic [TIME_W-1:0]  sched_clock = '0;
	logic [CNT_W-1:0]   sched_count = '0;

	tick_report_t tick_reports [$];
	tick_report_t report_due;
	int           mismatch_count = 0;
	int           cycle_count    = 0;
	bit           idling_on      = 1'b1;
	bit           hold_request   = 1'b0;
	int           hold_left      = 0;

	preemptive_priority_scheduler_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.slot       (slot),
		.arrival    (arrival),
		.burst      (burst),
		.prio       (prio),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ran        (ran),
		.run_slot   (run_slot),
		.time_now   (time_now),
		.finished   (finished),
		.first_run  (first_run),
		.turnaround (turnaround),
		.waiting    (waiting),
		.all_done   (all_done)
	);

	always #5 clk = ~clk;

	// The table reads as zero until loaded.
	initial begin
		for (int i = 0; i < MAX_TASKS_DEF; i++) begin
			sched_arrival[i] = '0;
			sched_burst[i]   = '0;
			sched_left[i]    = '0;
			sched_prio[i]    = '0;
			sched_start[i]   = '0;
			sched_done[i]    = 1'b0;
		end
	end

	// A load restarts the slot with its full burst; a zero burst is done at once.
	task automatic load_slot(input logic [SLOT_W-1:0] s, input logic [ARR_W-1:0] a,
			input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p);
		sched_arrival[s] = a;
		sched_burst[s]   = b;
		sched_left[s]    = b;
		sched_prio[s]    = p;
		sched_start[s]   = '0;
		sched_done[s]    = (b == '0);
	endtask

	// Pick the ready slot with the lowest priority value, run it for one tick.
	function automatic tick_report_t schedule_tick();
		tick_report_t      r;
		int                active;
		bit                found;
		int                best;
		logic [TIME_W-1:0] prev;
		logic [TIME_W-1:0] span;
		active = (int'(sched_count) > MAX_TASKS_DEF) ? MAX_TASKS_DEF : int'(sched_count);
		found  = 1'b0;
		best   = 0;
		for (int i = 0; i < active; i++) begin
			if (!sched_done[i] && sched_left[i] != '0 && sched_arrival[i] <= sched_clock) begin
				if (!found || sched_prio[i] < sched_prio[best] ||
						(sched_prio[i] == sched_prio[best] &&
						sched_arrival[i] < sched_arrival[best])) begin
					best  = i;
					found = 1'b1;
				end
			end
		end
		prev = sched_clock;
		if (sched_clock != CLOCK_MAX)
			sched_clock = sched_clock + 1'b1;
		r.ran        = found;
		r.run_slot   = '0;
		r.time_now   = sched_clock;
		r.finished   = 1'b0;
		r.first_run  = '0;
		r.turnaround = '0;
		r.waiting    = '0;
		if (found) begin
			r.run_slot = SLOT_W'(best);
			if (sched_left[best] == sched_burst[best])
				sched_start[best] = prev;
			r.first_run = sched_start[best];
			sched_left[best] = sched_left[best] - 1'b1;
			if (sched_left[best] == '0) begin
				span         = sched_clock - sched_arrival[best];
				r.finished   = 1'b1;
				r.turnaround = span;
				r.waiting    = (span >= sched_burst[best]) ? span - sched_burst[best] : '0;
				sched_done[best] = 1'b1;
			end
		end
		r.all_done = 1'b1;
		for (int i = 0; i < active; i++)
			if (!sched_done[i])
				r.all_done = 1'b0;
		return r;
	endfunction

	// Offer one word, hold it until accepted, then update the prediction.
	task automatic send_word(input logic m, input logic [SLOT_W-1:0] s,
			input logic [ARR_W-1:0] a, input logic [BURST_W-1:0] b,
			input logic [PRIO_W-1:0] p);
		while (idling_on && $urandom_range(99, 0) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		slot     <= s;
		arrival  <= a;
		burst    <= b;
		prio     <= p;
		do
			@(posedge clk);
		while (in_stall);
		if (m == MODE_TICK)
			tick_reports.push_back(schedule_tick());
		else
			load_slot(s, a, b, p);
	endtask

	task automatic send_tick();
		send_word(MODE_TICK, SLOT_W'($urandom), ARR_W'($urandom), BURST_W'($urandom),
			PRIO_W'($urandom));
	endtask

	// Mostly short tasks arriving just ahead of the clock, with some outliers.
	task automatic send_random_load(input int forced_slot);
		int                 active;
		int                 pick;
		logic [SLOT_W-1:0]  s;
		logic [ARR_W-1:0]   a;
		logic [BURST_W-1:0] b;
		logic [PRIO_W-1:0]  p;
		active = (int'(sched_count) > MAX_TASKS_DEF) ? MAX_TASKS_DEF : int'(sched_count);
		if (forced_slot >= 0)
			s = SLOT_W'(forced_slot);
		else if (active > 0 && $urandom_range(99, 0) < 75)
			s = SLOT_W'($urandom_range(active - 1, 0));
		else
			s = SLOT_W'($urandom_range(MAX_TASKS_DEF - 1, 0));
		if ($urandom_range(99, 0) < 85)
			a = sched_clock[ARR_W-1:0] + ARR_W'($urandom_range(12, 0));
		else
			a = ARR_W'($urandom);
		pick = $urandom_range(99, 0);
		if (pick < 80)
			b = BURST_W'($urandom_range(5, 1));
		else if (pick < 88)
			b = '0;
		else
			b = BURST_W'($urandom);
		if ($urandom_range(99, 0) < 60)
			p = PRIO_W'($urandom_range(7, 0));
		else
			p = PRIO_W'($urandom);
		send_word(MODE_LOAD, s, a, b, p);
	endtask

	task automatic run_random_mix(input int count, input int tick_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99, 0) < tick_pct)
				send_tick();
			else
				send_random_load(-1);
		end
	endtask

	// Stop offering words, let every report arrive and the scan finish.
	task automatic drain_schedule();
		in_valid <= 1'b0;
		while (tick_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic set_task_count(input logic [CNT_W-1:0] value);
		drain_schedule();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		sched_count = value;
		@(posedge clk);
	endtask

	// With no slots configured every tick is idle and all tasks count as done.
	task automatic test_empty_table();
		send_tick();
		send_tick();
	endtask

	// Hand-built table: ties on arrival and slot, preemption, zero burst,
	// a task that never arrives, reloads and the all-done state.
	task automatic test_directed_schedule();
		set_task_count(7'd6);
		send_word(MODE_LOAD, 6'd0, 16'd4, 16'd3, 8'd5);
		send_word(MODE_LOAD, 6'd1, 16'd4, 16'd1, 8'd5);
		send_word(MODE_LOAD, 6'd2, 16'd3, 16'd1, 8'd5);
		send_word(MODE_LOAD, 6'd3, 16'd0, 16'd0, 8'd0);
		send_word(MODE_LOAD, 6'd4, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_word(MODE_LOAD, 6'd5, 16'd6, 16'd2, 8'd0);
		send_word(MODE_LOAD, 6'd63, 16'hFFFF, 16'hFFFF, 8'hFF);
		repeat (9) send_tick();
		send_word(MODE_LOAD, 6'd2, 16'd0, 16'd1, 8'd0);
		send_word(MODE_LOAD, 6'd4, 16'd0, 16'd0, 8'd0);
		send_tick();
		send_tick();
	endtask

	// Every slot gets a task so that any task count is legal from here on.
	task automatic test_fill_table();
		for (int s = 0; s < MAX_TASKS_DEF; s++)
			send_random_load(s);
	endtask

	task automatic test_full_table();
		set_task_count(7'd64);
		run_random_mix(200, 55);
	endtask

	// Counts above the table size act as the full table.
	task automatic test_oversized_count();
		set_task_count(7'd127);
		run_random_mix(120, 55);
		set_task_count(7'd65);
		run_random_mix(60, 55);
	endtask

	task automatic test_single_slot();
		set_task_count(7'd1);
		run_random_mix(120, 55);
	endtask

	// The receiver holds off long enough for the block to stop taking words.
	task automatic test_output_backpressure();
		set_task_count(7'd64);
		hold_request = 1'b1;
		run_random_mix(150, 80);
	endtask

	task automatic test_steady_stream();
		set_task_count(CNT_W'($urandom_range(63, 2)));
		idling_on = 1'b0;
		run_random_mix(200, 55);
		idling_on = 1'b1;
	endtask

	task automatic test_random_counts();
		repeat (3) begin
			set_task_count(CNT_W'($urandom_range(64, 1)));
			run_random_mix(100, 55);
		end
		set_task_count(7'd0);
		run_random_mix(30, 60);
	endtask

	task automatic check_field(input string label, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	// Check each accepted report, then choose the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (tick_reports.size() == 0) begin
				$display("%0t: report with no tick waiting, expected none, actual slot %0d",
					$time, run_slot);
				mismatch_count++;
			end else begin
				report_due = tick_reports.pop_front();
				check_field("ran", TIME_W'(report_due.ran), TIME_W'(ran));
				check_field("run_slot", TIME_W'(report_due.run_slot), TIME_W'(run_slot));
				check_field("time_now", report_due.time_now, time_now);
				check_field("finished", TIME_W'(report_due.finished), TIME_W'(finished));
				check_field("first_run", report_due.first_run, first_run);
				check_field("turnaround", report_due.turnaround, turnaround);
				check_field("waiting", report_due.waiting, waiting);
				check_field("all_done", TIME_W'(report_due.all_done), TIME_W'(all_done));
			end
		end
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_STRETCH;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= idling_on && ($urandom_range(99, 0) < 29);
		end
	end

	// Give up if the run takes far longer than the slowest correct run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed_schedule();
		test_fill_table();
		test_full_table();
		test_oversized_count();
		test_single_slot();
		test_output_backpressure();
		test_steady_stream();
		test_random_counts();
		drain_schedule();
		if (mismatch_count == 0 && tick_reports.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
